// ===== design/stpax_pkg.sv =====
`default_nettype none

package stpax_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [7:0] MARGIN_RESET = 8'd20;
  localparam int         TRIALS       = 3;
  localparam logic [2:0] HITS_NEEDED  = 3'd4;

  localparam logic [1:0] MODE_CAL    = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_READY  = 2'd2;
  localparam logic [1:0] MODE_MOVE   = 2'd3;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;

  typedef struct packed {
    logic        action;
    logic        limit_hit;
    logic        both_hit;
    logic        move_left;
    logic [15:0] move_count;
  } item_t;

  typedef struct packed {
    logic        step_pulse;
    logic        dir_level;
    logic [1:0]  phase;
    logic        move_done;
    logic [15:0] travel_steps;
  } result_t;

endpackage

`default_nettype wire

// ===== design/stpax_ifs.sv =====
`default_nettype none

interface stpax_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        limit_hit;
  logic        both_hit;
  logic        move_left;
  logic [15:0] move_count;

  modport source (output valid, action, limit_hit, both_hit, move_left, move_count,
                  input ready);
  modport sink   (input valid, action, limit_hit, both_hit, move_left, move_count,
                  output ready);
endinterface

interface stpax_result_if;
  logic        valid;
  logic        ready;
  logic        step_pulse;
  logic        dir_level;
  logic [1:0]  phase;
  logic        move_done;
  logic [15:0] travel_steps;

  modport source (output valid, step_pulse, dir_level, phase, move_done, travel_steps,
                  input ready);
  modport sink   (input valid, step_pulse, dir_level, phase, move_done, travel_steps,
                  output ready);
endinterface

`default_nettype wire

// ===== design/stpax_core.sv =====
`default_nettype none

module stpax_core #(
  parameter int COUNT_BITS = stpax_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  wire stpax_pkg::item_t  cur_item,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  output stpax_pkg::result_t     res
);

  localparam int SUM_BITS = COUNT_BITS + 2;

  logic [7:0]            margin;
  logic [1:0]            mode, mode_next;
  logic                  dir_reg, dir_reg_next;
  logic [2:0]            hit_count, hit_count_next;
  // step_counter is also tracked as 3*step_q + step_r so the mean needs no divider
  logic [COUNT_BITS-1:0] step_counter, step_counter_next;
  logic [COUNT_BITS-1:0] step_q, step_q_next;
  logic [1:0]            step_r, step_r_next;
  logic [COUNT_BITS-1:0] trial_q [stpax_pkg::TRIALS];
  logic [COUNT_BITS-1:0] trial_q_next [stpax_pkg::TRIALS];
  logic [1:0]            trial_r [stpax_pkg::TRIALS];
  logic [1:0]            trial_r_next [stpax_pkg::TRIALS];
  logic [COUNT_BITS-1:0] travel_reg, travel_reg_next;
  logic [COUNT_BITS-1:0] center_counter, center_counter_next;
  logic [COUNT_BITS-1:0] remaining_steps, remaining_steps_next;

  logic [COUNT_BITS-1:0] inc_cnt, inc_q, center_inc, avg;
  logic [1:0]            inc_r;
  logic [SUM_BITS-1:0]   q_sum;
  logic [2:0]            r_sum;
  logic [1:0]            r_carry;
  logic                  pulse, done;

  always_comb begin
    inc_cnt = step_counter + 1'b1;
    if (&step_counter) begin
      // counter wraps to zero
      inc_q = '0;
      inc_r = 2'd0;
    end else if (step_r == 2'd2) begin
      inc_q = step_q + 1'b1;
      inc_r = 2'd0;
    end else begin
      inc_q = step_q;
      inc_r = step_r + 2'd1;
    end

    // mean of three trials; the third one is the count closing this run
    q_sum = SUM_BITS'(trial_q[0]) + SUM_BITS'(trial_q[1]) + SUM_BITS'(inc_q);
    r_sum = 3'(trial_r[0]) + 3'(trial_r[1]) + 3'(inc_r);
    if (r_sum >= 3'd6)      r_carry = 2'd2;
    else if (r_sum >= 3'd3) r_carry = 2'd1;
    else                    r_carry = 2'd0;
    avg = COUNT_BITS'(q_sum + SUM_BITS'(r_carry));

    center_inc = center_counter + 1'b1;
  end

  always_comb begin
    mode_next            = mode;
    dir_reg_next         = dir_reg;
    hit_count_next       = hit_count;
    step_counter_next    = step_counter;
    step_q_next          = step_q;
    step_r_next          = step_r;
    trial_q_next         = trial_q;
    trial_r_next         = trial_r;
    travel_reg_next      = travel_reg;
    center_counter_next  = center_counter;
    remaining_steps_next = remaining_steps;
    pulse                = 1'b0;
    done                 = 1'b0;

    case (mode)
      stpax_pkg::MODE_CAL: begin
        if (cur_item.action == stpax_pkg::ACT_TICK && !cur_item.both_hit) begin
          pulse = 1'b1;
          if (cur_item.limit_hit) begin
            dir_reg_next      = ~dir_reg;
            step_counter_next = '0;
            step_q_next       = '0;
            step_r_next       = 2'd0;
            for (int i = 0; i < stpax_pkg::TRIALS; i++) begin
              if (hit_count == 3'(i + 1)) begin
                trial_q_next[i] = inc_q;
                trial_r_next[i] = inc_r;
              end
            end
            hit_count_next = hit_count + 3'd1;
            if (hit_count_next == stpax_pkg::HITS_NEEDED) begin
              hit_count_next      = 3'd0;
              travel_reg_next     = (avg > COUNT_BITS'(margin)) ?
                                    avg - COUNT_BITS'(margin) : '0;
              center_counter_next = '0;
              mode_next           = stpax_pkg::MODE_CENTER;
            end
          end else begin
            step_counter_next = inc_cnt;
            step_q_next       = inc_q;
            step_r_next       = inc_r;
          end
        end
      end
      stpax_pkg::MODE_CENTER: begin
        if (cur_item.action == stpax_pkg::ACT_TICK) begin
          pulse               = 1'b1;
          center_counter_next = center_inc;
          if (center_inc >= (travel_reg >> 1)) mode_next = stpax_pkg::MODE_READY;
        end
      end
      stpax_pkg::MODE_READY: begin
        if (cur_item.action == stpax_pkg::ACT_MOVE) begin
          dir_reg_next         = cur_item.move_left;
          remaining_steps_next = COUNT_BITS'(cur_item.move_count);
          mode_next            = stpax_pkg::MODE_MOVE;
        end
      end
      default: begin
        if (cur_item.action == stpax_pkg::ACT_TICK) begin
          if (cur_item.limit_hit) begin
            remaining_steps_next = '0;
            done                 = 1'b1;
            mode_next            = stpax_pkg::MODE_READY;
          end else if (remaining_steps != '0) begin
            remaining_steps_next = remaining_steps - 1'b1;
            pulse                = 1'b1;
          end else begin
            done      = 1'b1;
            mode_next = stpax_pkg::MODE_READY;
          end
        end
      end
    endcase

    res.step_pulse   = pulse;
    res.dir_level    = dir_reg_next;
    res.phase        = mode_next;
    res.move_done    = done;
    res.travel_steps = 16'(travel_reg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin          <= stpax_pkg::MARGIN_RESET;
      mode            <= stpax_pkg::MODE_CAL;
      dir_reg         <= 1'b1;
      hit_count       <= 3'd0;
      step_counter    <= '0;
      step_q          <= '0;
      step_r          <= 2'd0;
      travel_reg      <= '0;
      center_counter  <= '0;
      remaining_steps <= '0;
      for (int i = 0; i < stpax_pkg::TRIALS; i++) begin
        trial_q[i] <= '0;
        trial_r[i] <= 2'd0;
      end
    end else begin
      if (cfg_we) margin <= cfg_wdata;
      if (step_en) begin
        mode            <= mode_next;
        dir_reg         <= dir_reg_next;
        hit_count       <= hit_count_next;
        step_counter    <= step_counter_next;
        step_q          <= step_q_next;
        step_r          <= step_r_next;
        trial_q         <= trial_q_next;
        trial_r         <= trial_r_next;
        travel_reg      <= travel_reg_next;
        center_counter  <= center_counter_next;
        remaining_steps <= remaining_steps_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/stepper_axis_calibrate_and_move_top.sv =====
// Stepper axis controller: calibrate against the limit switches, center,
// then run move commands.
// request: one item per step tick or move command (action, limit_hit,
//   both_hit, move_left, move_count), valid/ready handshake.
// result: one item back for every request item, in order: step_pulse,
//   dir_level, phase, move_done, travel_steps.
// cfg_we/cfg_wdata: writes the travel margin (reset 20); write only while
//   no item is in flight.
// Pipeline: a request item is taken into the input register, then its result
//   into the result register. Throughput: one item per cycle while results
//   are taken; the whole state update sits between those two registers.
// Reset: synchronous rst puts the axis in calibration with dir high, all
//   counters and the travel at zero, and both pipeline registers empty.
// Stall: a held result keeps its register; one more request item is still
//   taken into the input register, after which ready drops until the
//   result is taken.
`default_nettype none

module stepper_axis_calibrate_and_move_top #(
  parameter int COUNT_BITS = stpax_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  stpax_item_if.sink      request,
  stpax_result_if.source  result,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic               s1_valid;
  stpax_pkg::item_t   s1_item;
  logic               s1_adv;
  logic               out_valid;
  stpax_pkg::result_t out_data;
  stpax_pkg::result_t core_res;

  assign s1_adv        = s1_valid && (!out_valid || result.ready);
  assign request.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_item.action     <= request.action;
      s1_item.limit_hit  <= request.limit_hit;
      s1_item.both_hit   <= request.both_hit;
      s1_item.move_left  <= request.move_left;
      s1_item.move_count <= request.move_count;
    end
  end

  stpax_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (s1_adv),
    .cur_item  (s1_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_data <= core_res;
  end

  assign result.valid        = out_valid;
  assign result.step_pulse   = out_data.step_pulse;
  assign result.dir_level    = out_data.dir_level;
  assign result.phase        = out_data.phase;
  assign result.move_done    = out_data.move_done;
  assign result.travel_steps = out_data.travel_steps;

`ifndef SYNTHESIS
  a_no_pulse_on_done: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.step_pulse && result.move_done))
    else $error("step pulse together with move done");

  a_done_back_ready: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.move_done) |-> (result.phase == stpax_pkg::MODE_READY))
    else $error("move done outside ready phase");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled input item lost or changed");

  a_out_filled: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

// ===== tb/stpax_axis_checker.sv =====
module stpax_axis_checker
  import stpax_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  stpax_item_if          req_mon,
  stpax_result_if        res_mon,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  output int             n_fail,
  output int             n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Axis state as the block should hold it
  logic [7:0]  margin;
  logic [1:0]  mode;
  logic        dir_q;
  logic [2:0]  hits;
  logic [15:0] step_cnt;
  logic [15:0] center_cnt;
  logic [15:0] remaining;
  logic [15:0] travel;
  logic [15:0] trials [TRIALS];

  result_t step_reports [$];

  function automatic result_t advance_axis(input item_t it);
    result_t     r;
    logic [17:0] trial_sum;
    logic [15:0] mean;
    r = '0;
    case (mode)
      MODE_CAL: begin
        // both switches pressed: no step, limit ignored
        if (it.action == ACT_TICK && !it.both_hit) begin
          r.step_pulse = 1'b1;
          step_cnt = step_cnt + 16'd1;
          if (it.limit_hit) begin
            dir_q = ~dir_q;
            if (hits != 3'd0 && hits <= TRIALS) trials[hits - 3'd1] = step_cnt;
            step_cnt = '0;
            hits = hits + 3'd1;
          end
          if (hits == HITS_NEEDED) begin
            trial_sum = 18'(trials[0]) + 18'(trials[1]) + 18'(trials[2]);
            mean = 16'(trial_sum / TRIALS);
            hits = '0;
            travel = (mean > margin) ? mean - 16'(margin) : '0;
            center_cnt = '0;
            mode = MODE_CENTER;
          end
        end
      end
      MODE_CENTER: begin
        if (it.action == ACT_TICK) begin
          r.step_pulse = 1'b1;
          center_cnt = center_cnt + 16'd1;
          if (center_cnt >= (travel >> 1)) mode = MODE_READY;
        end
      end
      MODE_READY: begin
        if (it.action == ACT_MOVE) begin
          dir_q = it.move_left;
          remaining = it.move_count;
          mode = MODE_MOVE;
        end
      end
      default: begin
        if (it.action == ACT_TICK) begin
          if (it.limit_hit) begin
            remaining = '0;
            r.move_done = 1'b1;
            mode = MODE_READY;
          end else if (remaining != 16'd0) begin
            remaining = remaining - 16'd1;
            r.step_pulse = 1'b1;
          end else begin
            r.move_done = 1'b1;
            mode = MODE_READY;
          end
        end
      end
    endcase
    r.dir_level = dir_q;
    r.phase = mode;
    r.travel_steps = travel;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail++;
    end
  endfunction

  initial begin
    n_fail = 0;
    n_pending = 0;
  end

  always @(posedge clk) begin
    result_t want;
    item_t   it;
    if (rst) begin
      margin = MARGIN_RESET;
      mode = MODE_CAL;
      dir_q = 1'b1;
      hits = '0;
      step_cnt = '0;
      center_cnt = '0;
      remaining = '0;
      travel = '0;
      foreach (trials[i]) trials[i] = '0;
      step_reports.delete();
    end else begin
      if (cfg_we) margin = cfg_wdata;
      if (res_mon.valid && res_mon.ready) begin
        if (step_reports.size() == 0) begin
          $error("result item with no prediction waiting");
          n_fail++;
        end else begin
          want = step_reports.pop_front();
          check_field("step_pulse", want.step_pulse, res_mon.step_pulse);
          check_field("dir_level", want.dir_level, res_mon.dir_level);
          check_field("phase", want.phase, res_mon.phase);
          check_field("move_done", want.move_done, res_mon.move_done);
          check_field("travel_steps", want.travel_steps, res_mon.travel_steps);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        it = {req_mon.action, req_mon.limit_hit, req_mon.both_hit, req_mon.move_left,
              req_mon.move_count};
        step_reports.push_back(advance_axis(it));
      end
    end
    n_pending = step_reports.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stpax_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles;
  int         n_fail;
  int         n_pending;

  stpax_item_if   req_if();
  stpax_result_if res_if();

  stepper_axis_calibrate_and_move_top dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stpax_axis_checker axis_check (
    .clk       (clk),
    .rst       (rst),
    .req_mon   (req_if),
    .res_mon   (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic item_t item_of(input logic action, input logic limit, input logic both,
                                    input logic left, input logic [15:0] count);
    item_t it;
    it.action = action;
    it.limit_hit = limit;
    it.both_hit = both;
    it.move_left = left;
    it.move_count = count;
    return it;
  endfunction

  function automatic item_t rand_item();
    logic [31:0] bits;
    item_t       it;
    bits = $urandom;
    it = bits[19:0];
    return it;
  endfunction

  task automatic send(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= it.action;
    req_if.limit_hit <= it.limit_hit;
    req_if.both_hit <= it.both_hit;
    req_if.move_left <= it.move_left;
    req_if.move_count <= it.move_count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Ends on a falling edge with nothing in flight
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_margin(input logic [7:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // n_steps stepping ticks, the last one with a limit hit; ignored items mixed in
  task automatic cal_segment(input int unsigned n_steps, input int noise_pct);
    item_t it;
    for (int unsigned k = 1; k <= n_steps; k++) begin
      while ($urandom_range(0, 99) < noise_pct) begin
        it = rand_item();
        if ($urandom_range(0, 1)) begin
          it.action = ACT_MOVE;
        end else begin
          it.action = ACT_TICK;
          it.both_hit = 1'b1;
        end
        send(it);
      end
      it = rand_item();
      it.action = ACT_TICK;
      it.both_hit = 1'b0;
      it.limit_hit = (k == n_steps);
      send(it);
    end
  endtask

  // Move commands followed by their ticks, some cancelled, some noise
  task automatic random_moves(input int n_items);
    item_t       it;
    int unsigned span;
    int unsigned ticks;
    int          sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        send(rand_item());
        sent++;
      end else begin
        it = rand_item();
        it.action = ACT_MOVE;
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
        it.move_count = 16'(span);
        send(it);
        // long moves get cut short by a limit hit
        ticks = (span > 40) ? $urandom_range(1, 30) : span + 1;
        for (int unsigned j = 1; j <= ticks; j++) begin
          it = rand_item();
          it.action = ACT_TICK;
          it.limit_hit = (span > 40 && j == ticks) || ($urandom_range(0, 99) < 3);
          send(it);
        end
        sent += ticks + 1;
      end
    end
  endtask

  initial begin
    int unsigned trial_max;
    req_if.valid = 1'b0;
    req_if.action = ACT_TICK;
    req_if.limit_hit = 1'b0;
    req_if.both_hit = 1'b0;
    req_if.move_left = 1'b0;
    req_if.move_count = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_cycles = 0;
    send_idle_pct = 9;
    recv_stall_pct = 83;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_margin(8'hFF);

    // calibrating
    send(item_of(ACT_MOVE, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    send(item_of(ACT_TICK, 1'b1, 1'b1, 1'b0, 16'h0000));
    send(item_of(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000));
    send(item_of(ACT_TICK, 1'b0, 1'b0, 1'b1, 16'hFFFF));
    trial_max = $urandom_range(0, 1) ? 60 : 200;
    cal_segment($urandom_range(1, 40), 10);
    cal_segment($urandom_range(1, trial_max), 10);
    write_margin(8'h00);
    cal_segment($urandom_range(1, trial_max), 10);
    case ($urandom_range(0, 2))
      0: write_margin(8'h00);
      1: write_margin(8'hFF);
      default: write_margin(8'($urandom_range(0, 255)));
    endcase
    cal_segment($urandom_range(1, trial_max), 10);

    // centering: command and limit ignored, ticks step until half travel
    send(item_of(ACT_MOVE, 1'b0, 1'b0, 1'b1, 16'h1234));
    send(item_of(ACT_TICK, 1'b1, 1'b1, 1'b0, 16'h0000));
    repeat (trial_max / 2 + 2) send(item_of(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000));

    // ready and moving
    send(item_of(ACT_TICK, 1'b1, 1'b0, 1'b0, 16'h0000));
    send(item_of(ACT_MOVE, 1'b1, 1'b0, 1'b1, 16'h0000));
    send(item_of(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000));
    send(item_of(ACT_MOVE, 1'b0, 1'b0, 1'b0, 16'd3));
    repeat (4) send(item_of(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000));
    send(item_of(ACT_MOVE, 1'b0, 1'b1, 1'b1, 16'hFFFF));
    send(item_of(ACT_TICK, 1'b0, 1'b1, 1'b0, 16'h0000));
    send(item_of(ACT_MOVE, 1'b0, 1'b0, 1'b0, 16'd5));
    send(item_of(ACT_TICK, 1'b1, 1'b0, 1'b0, 16'h0000));

    random_moves(500);
    write_margin(8'h00);
    send_idle_pct = 83;
    recv_stall_pct = 9;
    random_moves(500);
    wait_drained();
    write_margin(8'hFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 150;
    random_moves(450);

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_fail == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
